// ----- rtl/core/mexp_pkg.sv -----
// Shared constants for the modular exponentiation unit.
// No dependencies.
package mexp_pkg;

  localparam int unsigned FieldW          = 32;
  localparam int unsigned OperandBitsDef  = 32;

endpackage

// ----- rtl/core/mexp_if.sv -----
// Valid/ready stream interfaces for operands and results.
// Depends on mexp_pkg for the field width.
interface mexp_in_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::FieldW-1:0]   base_value;
  logic [mexp_pkg::FieldW-1:0]   exponent_value;
  logic [mexp_pkg::FieldW-1:0]   modulus_value;

  modport source (output valid, base_value, exponent_value, modulus_value, input ready);
  modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

interface mexp_out_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::FieldW-1:0]   power_result;

  modport source (output valid, power_result, input ready);
  modport sink   (input valid, power_result, output ready);
endinterface

// ----- rtl/core/mexp_mulmod.sv -----
// Bit-serial modular multiplier: p = x * y mod m, one multiplier bit per cycle.
// Requires x <= m, m nonzero. Standalone; no package use.
module mexp_mulmod #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] p_o
);

  localparam int unsigned CntW = $clog2(W);

  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    x_q, y_q, m_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  logic [W+1:0] sum, m1, m2;

  // 2*acc + bit*x stays below 3m; subtract m or 2m.
  always_comb begin
    sum = {1'b0, acc_q, 1'b0} + (y_q[W-1] ? {2'b00, x_q} : '0);
    m1  = {2'b00, m_q};
    m2  = {1'b0, m_q, 1'b0};
    if (sum >= m2) begin
      acc_d = W'(sum - m2);
    end else if (sum >= m1) begin
      acc_d = W'(sum - m1);
    end else begin
      acc_d = W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(W - 1);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != '0);
      done_q <= (cnt_q == '0);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ----- rtl/core/modular_exponentiation_unit.sv -----
// Modular exponentiation: power_result = base ^ exponent mod modulus.
// Depends on mexp_pkg, mexp_if (stream interfaces) and mexp_mulmod.
//
// Usage: one operand transfer on in_i (base, exponent, modulus) yields one
// result transfer on out_o. Operands are masked to OPERAND_BITS bits.
// in_i.ready is high only while the sequencer is idle; one item is in work
// at a time.
// Work: the base is first reduced mod n, then the exponent is scanned from
// bit OPERAND_BITS-1 down to 0 with one squaring per bit and one extra
// multiply per set bit. All of it runs on a single bit-serial modular
// multiplier, so with B bits and P set exponent bits an item takes
// 1 + B + P products; a zero modulus returns 0 without the multiplier.
// The result sits in an output register; the next item may be taken while
// it waits. If the receiver stalls with a result still held, a finished
// item waits in the sequencer and input stays closed.
// Reset clears the sequencer and the output valid; no result survives it.
module modular_exponentiation_unit #(
  parameter int unsigned OPERAND_BITS = mexp_pkg::OperandBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mexp_in_if.sink  in_i,
  mexp_out_if.source out_o
);

  localparam int unsigned W    = OPERAND_BITS;
  localparam int unsigned FW   = mexp_pkg::FieldW;
  localparam int unsigned CntW = $clog2(W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [W-1:0]    base_q, base_d, exp_q, exp_d, mod_q, mod_d, acc_q, acc_d;
  logic [CntW-1:0] ecnt_q, ecnt_d;
  logic            ovld_q, ovld_d;
  logic [FW-1:0]   ores_q, ores_d;

  logic [W-1:0]  in_base, in_exp, in_mod;
  logic [FW-1:0] acc_ext;
  logic          in_xfer;

  logic         u_start, u_done;
  logic [W-1:0] u_x, u_y, u_m, u_p;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      in_base[i] = (i < FW) ? in_i.base_value[i % FW]     : 1'b0;
      in_exp[i]  = (i < FW) ? in_i.exponent_value[i % FW] : 1'b0;
      in_mod[i]  = (i < FW) ? in_i.modulus_value[i % FW]  : 1'b0;
    end
    for (int j = 0; j < FW; j++) begin
      acc_ext[j] = (j < W) ? acc_q[j % W] : 1'b0;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (u_start),
    .x_i     (u_x),
    .y_i     (u_y),
    .m_i     (u_m),
    .done_o  (u_done),
    .p_o     (u_p)
  );

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    exp_d   = exp_q;
    mod_d   = mod_q;
    acc_d   = acc_q;
    ecnt_d  = ecnt_q;
    ovld_d  = ovld_q && !out_o.ready;
    ores_d  = ores_q;
    u_start = 1'b0;
    u_x     = u_p;
    u_y     = u_p;
    u_m     = mod_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          exp_d  = in_exp;
          mod_d  = in_mod;
          ecnt_d = CntW'(W - 1);
          if (in_mod == '0) begin
            acc_d   = '0;
            state_d = S_OUT;
          end else begin
            acc_d   = (in_mod == W'(1)) ? '0 : W'(1);
            u_start = 1'b1;
            u_x     = W'(1);
            u_y     = in_base;
            u_m     = in_mod;
            state_d = S_RED;
          end
        end
      end
      S_RED: begin
        if (u_done) begin
          base_d  = u_p;
          u_start = 1'b1;
          u_x     = acc_q;
          u_y     = acc_q;
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        if (u_done) begin
          acc_d = u_p;
          if (exp_q[W-1]) begin
            u_start = 1'b1;
            u_x     = base_q;
            u_y     = u_p;
            state_d = S_MUL;
          end else if (ecnt_q == '0) begin
            state_d = S_OUT;
          end else begin
            ecnt_d  = ecnt_q - 1'b1;
            exp_d   = {exp_q[W-2:0], 1'b0};
            u_start = 1'b1;
          end
        end
      end
      S_MUL: begin
        if (u_done) begin
          acc_d = u_p;
          if (ecnt_q == '0) begin
            state_d = S_OUT;
          end else begin
            ecnt_d  = ecnt_q - 1'b1;
            exp_d   = {exp_q[W-2:0], 1'b0};
            u_start = 1'b1;
            state_d = S_SQR;
          end
        end
      end
      S_OUT: begin
        if (!ovld_q || out_o.ready) begin
          ovld_d  = 1'b1;
          ores_d  = acc_ext;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    ecnt_q <= ecnt_d;
    ores_q <= ores_d;
  end

  assign out_o.valid        = ovld_q;
  assign out_o.power_result = ores_q;

  a_xfer_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE))
    else $error("operand transfer did not start the sequencer");

  a_product_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (u_done && (state_q == S_RED || state_q == S_SQR || state_q == S_MUL))
      |-> (u_p < mod_q))
    else $error("modular product not below modulus");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_d && !ovld_q) |-> (state_q == S_OUT))
    else $error("result raised outside output state");

  a_nonzero_mod_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RED) |-> (mod_q != '0))
    else $error("multiplier run with zero modulus");

endmodule
